// ===== src/gsc_pkg.sv =====
`timescale 1ns / 1ps

package gsc_pkg;

    // transaction codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam int MAP_DIM_W = 9;
    localparam logic [MAP_DIM_W-1:0] MAP_DIM_RESET = 9'd256;

    // slope in signed q16.16, clamped to +-20000
    localparam int SLOPE_W = 32;
    localparam logic [SLOPE_W-1:0] SLOPE_SAT = 32'd1310720000;

    // shared divider widths
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 32;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_PREP,
        S_SLOPE_DIV,
        S_COL_INIT,
        S_COL_MUL,
        S_COL_CHK,
        S_COL_TEST,
        S_ROW_INIT,
        S_ROW_TOP,
        S_ROW_DIV,
        S_ROW_TEST,
        S_DONE
    } state_t;

endpackage

// ===== src/gsc_grid_mem.sv =====
`timescale 1ns / 1ps

module gsc_grid_mem #(
    parameter int ROWS = 256,
    parameter int COLS = 256
) (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [$clog2(ROWS)-1:0] rd_addr,
    output logic [COLS-1:0]         rd_data,
    input  logic                    wr_en,
    input  logic [$clog2(ROWS)-1:0] wr_addr,
    input  logic [COLS-1:0]         wr_data
);

    logic [COLS-1:0] mem [ROWS];

    // one row per word, write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/gsc_div.sv =====
`timescale 1ns / 1ps

module gsc_div
    import gsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  active_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(DIVIDEND_W - 1);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : DIVISOR_W'(trial);
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/grid_segment_collision_check_core.sv =====
`timescale 1ns / 1ps

// Segment check against a one-bit occupancy grid.
// Input transaction: taken at a clock edge with start high and busy low.
// opcode write sets one cell (cell_row, cell_col, cell_blocked) if it lies in
// the grid, and gives no result. opcode check tests the segment from
// (start_x, start_y) to (end_x, end_y), signed fixed point, and gives one
// result: hits_obstacle, valid for the single cycle in which done is high.
// The receiver cannot stall; results are taken when shown.
// A check may do a slope division, a column walk and a row walk; each row
// walked needs one 48-step pass through the shared bit-serial divider.
// busy stays high for a whole transaction, including the result cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are taken at any time, also while busy.
// After reset the grid memory is cleared one row per cycle, every row,
// with busy high; map_width and map_height come up as 256.
module grid_segment_collision_check_core
    import gsc_pkg::*;
#(
    parameter int GRID_COLS       = 256,
    parameter int GRID_ROWS       = 256,
    parameter int COORD_FRAC_BITS = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 opcode,
    input  logic signed [15:0]   start_x,
    input  logic signed [15:0]   start_y,
    input  logic signed [15:0]   end_x,
    input  logic signed [15:0]   end_y,
    input  logic [7:0]           cell_row,
    input  logic [7:0]           cell_col,
    input  logic                 cell_blocked,
    output logic                 done,
    output logic                 hits_obstacle,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAP_DIM_W-1:0] cfg_data
);

    localparam int ROW_AW   = $clog2(GRID_ROWS);
    localparam int COL_AW   = $clog2(GRID_COLS);
    localparam int SCALE_SH = COORD_FRAC_BITS + 16;

    state_t state_reg, state_next;

    logic [MAP_DIM_W-1:0] map_w_reg, map_h_reg;

    logic signed [15:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [15:0] x1_next, y1_next, x2_next, y2_next;
    logic [7:0]         wrow_reg, wrow_next, wcol_reg, wcol_next;
    logic               blk_reg, blk_next;
    logic signed [SLOPE_W-1:0] m_reg, m_next;
    logic [15:0]        ix_reg, ix_next, ixhi_reg, ixhi_next;
    logic [15:0]        iy_reg, iy_next, yhi_reg, yhi_next;
    logic [15:0]        tcol_reg, tcol_next;
    logic signed [49:0] prod_reg, prod_next;
    logic               nneg_reg, nneg_next;
    logic               hit_reg, hit_next;
    logic [ROW_AW-1:0]  clr_reg, clr_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 mem_rd_en, mem_wr_en;
    logic [ROW_AW-1:0]    mem_rd_addr, mem_wr_addr;
    logic [GRID_COLS-1:0] mem_rd_data, mem_wr_data;

    // datapath temporaries
    logic signed [16:0] dx, dy;
    logic [15:0]        dx_mag, dy_mag;
    logic [17:0]        ix_scaled, iy_scaled;
    logic signed [17:0] dcol, nrow;
    logic [15:0]        n_mag;
    logic [SLOPE_W-1:0] m_mag, slope_mag;
    logic signed [50:0] y_col, x_row, q_signed;
    logic [50:0]        h_bound, w_bound;
    logic [15:0]        row_of_y, col_of_x;
    logic               slope_neg;

    // inside the grid and inside the map in use
    function automatic logic cell_ok(
        input logic [15:0]          row,
        input logic [15:0]          col,
        input logic [MAP_DIM_W-1:0] mw,
        input logic [MAP_DIM_W-1:0] mh
    );
        cell_ok = (row < 16'(mh)) && (col < 16'(mw)) &&
                  (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
    endfunction

    gsc_grid_mem #(
        .ROWS (GRID_ROWS),
        .COLS (GRID_COLS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    gsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg <= MAP_DIM_RESET;
            map_h_reg <= MAP_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAP_WIDTH:  map_w_reg <= cfg_data;
                CFG_MAP_HEIGHT: map_h_reg <= cfg_data;
                default:        map_w_reg <= map_w_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hit_reg   <= hit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        wrow_reg <= wrow_next;
        wcol_reg <= wcol_next;
        blk_reg  <= blk_next;
        m_reg    <= m_next;
        ix_reg   <= ix_next;
        ixhi_reg <= ixhi_next;
        iy_reg   <= iy_next;
        yhi_reg  <= yhi_next;
        tcol_reg <= tcol_next;
        prod_reg <= prod_next;
        nneg_reg <= nneg_next;
    end

    // arithmetic on the held segment
    always_comb
    begin
        dx     = 17'(x2_reg) - 17'(x1_reg);
        dy     = 17'(y2_reg) - 17'(y1_reg);
        dx_mag = 16'(dx[16] ? -dx : dx);
        dy_mag = 16'(dy[16] ? -dy : dy);
        slope_neg = dx[16] ^ dy[16];

        ix_scaled = 18'(ix_reg) << COORD_FRAC_BITS;
        iy_scaled = 18'(iy_reg) << COORD_FRAC_BITS;
        dcol      = $signed(ix_scaled) - 18'(x1_reg);
        nrow      = $signed(iy_scaled) - 18'(y1_reg);
        n_mag     = 16'(nrow[17] ? -nrow : nrow);
        m_mag     = m_reg[SLOPE_W-1] ? SLOPE_W'(-m_reg) : SLOPE_W'(m_reg);
        prod_next = m_reg * dcol;

        slope_mag = (div_rsp.quotient > DIVIDEND_W'(SLOPE_SAT)) ? SLOPE_SAT
                    : div_rsp.quotient[SLOPE_W-1:0];

        h_bound = 51'(map_h_reg) << SCALE_SH;
        w_bound = 51'(map_w_reg) << SCALE_SH;

        y_col    = 51'(prod_reg) + $signed({20'd0, y1_reg[14:0], 16'd0});
        row_of_y = 16'(y_col >> SCALE_SH);

        q_signed = $signed({3'b000, div_rsp.quotient});
        if (nneg_reg ^ m_reg[SLOPE_W-1])
        begin
            q_signed = -q_signed;
        end
        x_row    = $signed({20'd0, x1_reg[14:0], 16'd0}) + q_signed;
        col_of_x = 16'(x_row >> SCALE_SH);
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        hit_next   = hit_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        wrow_next  = wrow_reg;
        wcol_next  = wcol_reg;
        blk_next   = blk_reg;
        m_next     = m_reg;
        ix_next    = ix_reg;
        ixhi_next  = ixhi_reg;
        iy_next    = iy_reg;
        yhi_next   = yhi_reg;
        tcol_next  = tcol_reg;
        nneg_next  = nneg_reg;

        // row offset scaled by 2^32 over the slope magnitude
        div_req.start    = 1'b0;
        div_req.dividend = {n_mag, 32'd0};
        div_req.divisor  = m_mag;

        mem_rd_en   = 1'b0;
        mem_rd_addr = ROW_AW'(wrow_reg);
        mem_wr_en   = 1'b0;
        mem_wr_addr = ROW_AW'(wrow_reg);
        mem_wr_data = mem_rd_data;
        mem_wr_data[COL_AW'(wcol_reg)] = blk_reg;

        busy = (state_reg != S_IDLE);
        done = 1'b0;

        unique case (state_reg)
            // sweep zeros through every row after reset
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == ROW_AW'(GRID_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take a transaction
            S_IDLE:
            begin
                if (start)
                begin
                    x1_next   = start_x;
                    y1_next   = start_y;
                    x2_next   = end_x;
                    y2_next   = end_y;
                    wrow_next = cell_row;
                    wcol_next = cell_col;
                    blk_next  = cell_blocked;
                    if (opcode == OP_CHECK)
                    begin
                        state_next = S_PREP;
                    end
                    else if ((32'(cell_row) < GRID_ROWS) && (32'(cell_col) < GRID_COLS))
                    begin
                        state_next = S_WR_RD;
                    end
                end
            end

            // cell write: read the row, patch one bit, write back
            S_WR_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_WR_WB;
            end

            S_WR_WB:
            begin
                mem_wr_en  = 1'b1;
                state_next = S_IDLE;
            end

            // special cases and slope division
            S_PREP:
            begin
                if (x1_reg[15] || y1_reg[15] || x2_reg[15] || y2_reg[15])
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (dx == '0 && dy == '0)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (dx == '0)
                begin
                    m_next     = dy[16] ? -$signed(SLOPE_SAT) : $signed(SLOPE_SAT);
                    state_next = S_ROW_INIT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {16'd0, dy_mag, 16'd0};
                    div_req.divisor  = {16'd0, dx_mag};
                    state_next       = S_SLOPE_DIV;
                end
            end

            S_SLOPE_DIV:
            begin
                if (div_rsp.done)
                begin
                    m_next = slope_neg ? $signed(-slope_mag) : $signed(slope_mag);
                    if (slope_mag == SLOPE_SAT)
                    begin
                        state_next = S_ROW_INIT;
                    end
                    else
                    begin
                        state_next = S_COL_INIT;
                    end
                end
            end

            // column walk
            S_COL_INIT:
            begin
                if (x1_reg < x2_reg)
                begin
                    ix_next   = 16'(x1_reg >>> COORD_FRAC_BITS);
                    ixhi_next = 16'(x2_reg >>> COORD_FRAC_BITS);
                end
                else
                begin
                    ix_next   = 16'(x2_reg >>> COORD_FRAC_BITS);
                    ixhi_next = 16'(x1_reg >>> COORD_FRAC_BITS);
                end
                state_next = S_COL_MUL;
            end

            S_COL_MUL:
            begin
                state_next = S_COL_CHK;
            end

            S_COL_CHK:
            begin
                if (y_col > 0 && y_col < $signed(h_bound) &&
                    cell_ok(row_of_y, ix_reg, map_w_reg, map_h_reg))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ROW_AW'(row_of_y);
                    state_next  = S_COL_TEST;
                end
                else if (ix_reg == ixhi_reg)
                begin
                    state_next = (m_reg != '0) ? S_ROW_INIT : S_DONE;
                    hit_next   = 1'b0;
                end
                else
                begin
                    ix_next    = ix_reg + 1'b1;
                    state_next = S_COL_MUL;
                end
            end

            S_COL_TEST:
            begin
                if (mem_rd_data[COL_AW'(ix_reg)])
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (ix_reg == ixhi_reg)
                begin
                    state_next = (m_reg != '0) ? S_ROW_INIT : S_DONE;
                    hit_next   = 1'b0;
                end
                else
                begin
                    ix_next    = ix_reg + 1'b1;
                    state_next = S_COL_MUL;
                end
            end

            // row walk
            S_ROW_INIT:
            begin
                if (y1_reg < y2_reg)
                begin
                    iy_next  = 16'(y1_reg >>> COORD_FRAC_BITS);
                    yhi_next = y2_reg;
                end
                else
                begin
                    iy_next  = 16'(y2_reg >>> COORD_FRAC_BITS);
                    yhi_next = y1_reg;
                end
                state_next = S_ROW_TOP;
            end

            S_ROW_TOP:
            begin
                if (iy_scaled < {2'b00, yhi_reg})
                begin
                    div_req.start = 1'b1;
                    nneg_next     = nrow[17];
                    state_next    = S_ROW_DIV;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
            end

            S_ROW_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (x_row > 0 && x_row < $signed(w_bound) &&
                        cell_ok(iy_reg, col_of_x, map_w_reg, map_h_reg))
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ROW_AW'(iy_reg);
                        tcol_next   = col_of_x;
                        state_next  = S_ROW_TEST;
                    end
                    else
                    begin
                        iy_next    = iy_reg + 1'b1;
                        state_next = S_ROW_TOP;
                    end
                end
            end

            S_ROW_TEST:
            begin
                if (mem_rd_data[COL_AW'(tcol_reg)])
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    iy_next    = iy_reg + 1'b1;
                    state_next = S_ROW_TOP;
                end
            end

            // present the result for one cycle
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign hits_obstacle = hit_reg;

endmodule
